[sv/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants of the sliding window median block
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int DATA_W = 32;   // sample and median width
  localparam int CFG_W  = 7;    // window_size register width

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CFG_W-1:0]  cfg_t;

endpackage

[sv/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median
// median of the most recent window_size samples (clamped to 1..WINDOW_MAX),
// kept as a ring of raw samples plus a sorted copy that is merged once per item
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------
//  input    | in        | in_valid / in_ready   | sample
//  output   | out       | out_valid / out_ready | median, window_wrapped
//  config   | in        | psel/penable/pready   | paddr, pwdata, prdata
//
//  a new sample is accepted only in the idle state, once the previous item is
//  done; the merge pass reads the sorted bank one entry a cycle through its
//  single read port
//  a result waits in the output register while the next item is merged; the
//  block holds in its final state only if that register is still full
//  reset clears fill count, ring position, window_size (to 5) and handshakes;
//  no clearing pass, the memories need none
//
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        in_valid,
  output logic        in_ready,
  input  data_t       sample,
  // result item
  output logic        out_valid,
  input  logic        out_ready,
  output data_t       median,
  output logic        window_wrapped,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ring index bits, count bits, sorted memory address bits
  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW  = $clog2(WINDOW_MAX + 1);
  localparam int SAW = AW + 1;

  // controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // register index
  localparam logic REG_WINDOW_SIZE = 1'b0;

  logic [1:0]    state;
  cfg_t          window_size;
  logic [SW-1:0] fill_count;
  logic [AW-1:0] wp;
  logic          bank;

  // per item context
  data_t         v;
  logic          full;
  logic [SW-1:0] n;
  logic [SW-1:0] rj;
  logic          rvalid;
  logic [AW-1:0] ridx;
  logic          removed;
  logic [AW-1:0] p;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  data_t         med_a;
  data_t         med_b;

  // effective window size
  logic [31:0]   size_ext;
  logic [SW-1:0] eff_size;

  always_comb begin
    size_ext = 32'(window_size);
    if (size_ext == 32'd0) begin
      eff_size = SW'(1);
    end else if (size_ext > 32'(WINDOW_MAX)) begin
      eff_size = SW'(WINDOW_MAX);
    end else begin
      eff_size = SW'(size_ext);
    end
  end

  // register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size) : 32'd0;

  // input accept and the count after this item
  logic          accept;
  logic          full_now;
  logic [SW-1:0] cnt_new;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign full_now = (fill_count == eff_size);
  assign cnt_new  = full_now ? fill_count : fill_count + SW'(1);

  // ring access on accept: new sample in, evicted sample out
  data_t old_sample;

  swm_ring_mem #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .en    (accept),
    .addr  (wp),
    .wdata (sample),
    .rdata (old_sample)
  );

  // merge pass: read the current sorted bank one entry a cycle
  logic           issue;
  logic [SAW-1:0] rbase;
  logic [SAW-1:0] wbase;
  logic [SAW-1:0] s_raddr;
  logic [SAW-1:0] s_waddr;
  logic           s_we;
  data_t          s_wdata;
  data_t          e;
  logic           kill;
  logic           gt;
  logic [AW:0]    pos_w;
  logic [AW-1:0]  pos;

  assign issue   = (state == ST_RUN) && (rj < n);
  assign rbase   = bank ? SAW'(WINDOW_MAX) : '0;
  assign wbase   = bank ? '0 : SAW'(WINDOW_MAX);
  assign s_raddr = rbase + SAW'(rj[AW-1:0]);

  // the evicted sample leaves once; every other entry moves up by one if the
  // new sample lands in front of it, down by one once the eviction is behind
  assign kill  = full && !removed && (e == old_sample);
  assign gt    = (e > v);
  assign pos_w = {1'b0, ridx} - (AW+1)'(removed) + (AW+1)'(gt);
  assign pos   = pos_w[AW-1:0];

  always_comb begin
    s_we    = 1'b0;
    s_waddr = wbase + SAW'(pos);
    s_wdata = e;
    if (state == ST_INS) begin
      s_we    = 1'b1;
      s_waddr = wbase + SAW'(p);
      s_wdata = v;
    end else if (rvalid && !kill) begin
      s_we = 1'b1;
    end
  end

  swm_sort_mem #(
    .DEPTH (2 * WINDOW_MAX),
    .AW    (SAW)
  ) u_sort (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (e)
  );

  // end of item
  logic  wrap;
  logic  out_free;
  data_t med_sum;

  assign wrap     = ((SW'(wp) + SW'(1)) == eff_size);
  assign out_free = !out_valid || out_ready;
  // floor of the mean without a 33-bit sum
  assign med_sum  = (med_a >> 1) + (med_b >> 1) + data_t'(med_a[0] & med_b[0]);

  // payload registers of the item context
  always_ff @(posedge clk) begin
    if (accept) begin
      v  <= sample;
      lo <= AW'((cnt_new - SW'(1)) >> 1);
      hi <= AW'(cnt_new >> 1);
    end
    if (rvalid && !kill) begin
      if (pos == lo) begin
        med_a <= e;
      end
      if (pos == hi) begin
        med_b <= e;
      end
    end
    if (state == ST_INS) begin
      if (p == lo) begin
        med_a <= v;
      end
      if (p == hi) begin
        med_b <= v;
      end
    end
    if ((state == ST_FIN) && out_free) begin
      median         <= med_sum;
      window_wrapped <= wrap;
    end
    ridx <= rj[AW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_size <= CFG_W'(5);
      fill_count  <= '0;
      wp          <= '0;
      bank        <= 1'b0;
      full        <= 1'b0;
      n           <= '0;
      rj          <= '0;
      rvalid      <= 1'b0;
      removed     <= 1'b0;
      p           <= '0;
      out_valid   <= 1'b0;
    end else begin
      rvalid <= issue;
      if (issue) begin
        rj <= rj + SW'(1);
      end
      if (rvalid && kill) begin
        removed <= 1'b1;
      end
      if (rvalid && !kill && !gt) begin
        p <= p + AW'(1);
      end
      // result register: loaded at the end of an item, freed when taken
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            full    <= full_now;
            n       <= fill_count;
            rj      <= '0;
            removed <= 1'b0;
            p       <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          // drained: nothing issued and nothing in flight
          if (!issue && !rvalid) begin
            state <= ST_INS;
          end
        end
        ST_INS: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            wp        <= wrap ? '0 : wp + AW'(1);
            if (!full) begin
              fill_count <= fill_count + SW'(1);
            end
            bank  <= ~bank;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // a new window size restarts the window
      if (cfg_wr) begin
        window_size <= pwdata[CFG_W-1:0];
        fill_count  <= '0;
        wp          <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= eff_size)
    else $error("fill count beyond window size");

  // ring position tracks the fill count until the ring is full
  a_wp_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_count != eff_size) |-> (SW'(wp) == fill_count))
    else $error("ring position out of step with fill count");

  // a full window must have found and dropped the evicted sample
  a_evicted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS && full) |-> removed)
    else $error("evicted sample not found in sorted bank");

  // the new sample goes after every kept entry not above it, so within range
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS) |-> (SW'(p) <= n))
    else $error("insert position beyond held count");

  // an accepted item starts the merge pass
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN))
    else $error("merge pass did not start");
`endif

endmodule

[sv/swm_ring_mem.sv]
// ----------------------------------------------------------------------------
// swm_ring_mem
// ring of raw samples, one read-first port: the old entry comes out as the
// new sample goes in
// ----------------------------------------------------------------------------
module swm_ring_mem
  import swm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  data_t         wdata,
  output data_t         rdata
);

  data_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

[sv/swm_sort_mem.sv]
// ----------------------------------------------------------------------------
// swm_sort_mem
// two banks of the sorted window, one write port and one registered read port
// ----------------------------------------------------------------------------
module swm_sort_mem
  import swm_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  data_t         wdata,
  input  logic [AW-1:0] raddr,
  output data_t         rdata
);

  data_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
